FILE: hdl/phase_comparator_characteristic_macros.svh
// ----------------------------------------------------------------------------
// Phase comparator assertion macros
// Shared concurrent assertion forms used by the phase comparator RTL.
// ----------------------------------------------------------------------------
`ifndef PHASE_COMPARATOR_CHARACTERISTIC_MACROS_SVH
`define PHASE_COMPARATOR_CHARACTERISTIC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hdl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// Phase comparator package
// Widths, latencies, constants, codes and shared types of the comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int NSTG = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int Z_W    = PROD_W + 1;
    localparam int XY_W   = PROD_W + 4;
    localparam int ANG_W  = 26;
    localparam int TH_W   = 18;
    localparam int R_W    = 19;
    localparam int MAX_W  = 17;
    localparam int MOD_W  = MAX_W + 1;
    localparam int SX_W   = 33;
    localparam int SP_W   = 64;
    localparam int GAIN_W = 32;
    localparam int P_W    = GAIN_W + R_W;
    localparam int OUT_W  = 48;
    localparam int CFG_IDX_W = 2;

    localparam int ANGLE_LAT = NSTG + 4;
    localparam int PF_LAT    = MOD_W + 2;
    localparam int SN_LAT    = NSTG + 3;
    localparam int CHR_LAT   = (PF_LAT > SN_LAT) ? PF_LAT : SN_LAT;
    localparam int SHAPE_LAT = CHR_LAT + 1;
    localparam int TOTAL_LAT = ANGLE_LAT + SHAPE_LAT + 2;

    localparam logic signed [ANG_W-1:0] ANG_90   = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] ANG_RND  = 26'sd128;
    localparam logic signed [ANG_W-1:0] ANG_180Q = 26'sd46080;
    localparam logic signed [ANG_W-1:0] ANG_360Q = 26'sd92160;

    localparam logic signed [TH_W-1:0] TH_90  = 18'sd23040;
    localparam logic signed [TH_W-1:0] TH_180 = 18'sd46080;

    localparam logic signed [SX_W-1:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [31:0]     RAD2DEG   = 32'sd961263669;
    localparam logic signed [SP_W-1:0] SIN_RND   = 64'sh0000_1000_0000_0000;

    localparam logic signed [P_W-1:0] OUT_MAX = 51'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [P_W-1:0] OUT_MIN = -51'sh0_8000_0000_0000;

    localparam logic [1:0] MODE_PF  = 2'd0;
    localparam logic [1:0] MODE_SIN = 2'd1;
    localparam logic [1:0] MODE_TRI = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd2;

    localparam logic [1:0]         MODE_RST = MODE_PF;
    localparam logic [GAIN_W-1:0]  GAIN_RST = 32'd65536;
    localparam logic [MAX_W-1:0]   MAX_RST  = 17'd92160;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [GAIN_W-1:0] gain;
        logic [MAX_W-1:0]         max_angle;
    } t_cfg;

    typedef struct packed {
        logic                   vld;
        logic signed [TH_W-1:0] th;
    } t_ang;

    typedef struct packed {
        logic                  vld;
        logic signed [R_W-1:0] r;
    } t_shp;

    // atan(2^-i) in units of 2^-16 degree.
    function automatic logic signed [ANG_W-1:0] atan_val(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pcc_angle.sv
// ----------------------------------------------------------------------------
// Phase comparator angle measurement
// Forms x1*conj(x2) and finds its angle with a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_angle (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic signed [15:0]  i_in1_real,
    input  wire logic signed [15:0]  i_in1_imag,
    input  wire logic signed [15:0]  i_in2_real,
    input  wire logic signed [15:0]  i_in2_imag,
    output pcc_pkg::t_ang            o_ang
);

    localparam int SW     = pcc_pkg::SAMPLE_WIDTH;
    localparam int PROD_W = pcc_pkg::PROD_W;
    localparam int Z_W    = pcc_pkg::Z_W;
    localparam int XY_W   = pcc_pkg::XY_W;
    localparam int ANG_W  = pcc_pkg::ANG_W;
    localparam int TH_W   = pcc_pkg::TH_W;
    localparam int NSTG   = pcc_pkg::NSTG;

    logic signed [SW-1:0] w_a, w_b, w_c, w_d;

    // Only the low SAMPLE_WIDTH bits of each port carry the sample.
    assign w_a = $signed(SW'($unsigned(i_in1_real)));
    assign w_b = $signed(SW'($unsigned(i_in1_imag)));
    assign w_c = $signed(SW'($unsigned(i_in2_real)));
    assign w_d = $signed(SW'($unsigned(i_in2_imag)));

    logic signed [PROD_W-1:0] r_ac, r_bd, r_bc, r_ad;
    logic                     r_v1;

    always_ff @(posedge i_clk) begin
        r_ac <= w_a * w_c;
        r_bd <= w_b * w_d;
        r_bc <= w_b * w_c;
        r_ad <= w_a * w_d;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
        end
    end

    logic signed [Z_W-1:0] r_zr, r_zi;
    logic                  r_v2;

    always_ff @(posedge i_clk) begin
        r_zr <= Z_W'(r_ac) + Z_W'(r_bd);
        r_zi <= Z_W'(r_bc) - Z_W'(r_ad);
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    logic signed [XY_W-1:0]  r_x   [0:NSTG];
    logic signed [XY_W-1:0]  r_y   [0:NSTG];
    logic signed [ANG_W-1:0] r_ang [0:NSTG];
    logic                    r_zero[0:NSTG];
    logic                    r_vs  [0:NSTG];

    logic signed [XY_W-1:0]  w_zrx, w_zix, n_x0, n_y0;
    logic signed [ANG_W-1:0] n_ang0;

    assign w_zrx = XY_W'(r_zr);
    assign w_zix = XY_W'(r_zi);

    // A left-half vector is turned by a quarter turn so the CORDIC converges.
    always_comb begin
        n_x0   = w_zrx;
        n_y0   = w_zix;
        n_ang0 = '0;
        if (r_zr < 0) begin
            if (r_zi >= 0) begin
                n_x0   = w_zix;
                n_y0   = -w_zrx;
                n_ang0 = pcc_pkg::ANG_90;
            end else begin
                n_x0   = -w_zix;
                n_y0   = w_zrx;
                n_ang0 = -pcc_pkg::ANG_90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_ang[0]  <= n_ang0;
        r_zero[0] <= (r_zr == '0) && (r_zi == '0);
        if (!i_rst_n) begin
            r_vs[0] <= 1'b0;
        end else begin
            r_vs[0] <= r_v2;
        end
    end

    for (genvar gi = 0; gi < NSTG; gi++) begin : g_cordic
        logic signed [XY_W-1:0] w_xs, w_ys;
        assign w_xs = r_x[gi] >>> gi;
        assign w_ys = r_y[gi] >>> gi;

        always_ff @(posedge i_clk) begin
            if (r_y[gi] >= 0) begin
                r_x[gi+1]   <= r_x[gi] + w_ys;
                r_y[gi+1]   <= r_y[gi] - w_xs;
                r_ang[gi+1] <= r_ang[gi] + pcc_pkg::atan_val(gi);
            end else begin
                r_x[gi+1]   <= r_x[gi] - w_ys;
                r_y[gi+1]   <= r_y[gi] + w_xs;
                r_ang[gi+1] <= r_ang[gi] - pcc_pkg::atan_val(gi);
            end
            r_zero[gi+1] <= r_zero[gi];
            if (!i_rst_n) begin
                r_vs[gi+1] <= 1'b0;
            end else begin
                r_vs[gi+1] <= r_vs[gi];
            end
        end
    end

    logic signed [ANG_W-1:0] w_thr, n_thw;
    logic signed [TH_W-1:0]  r_th;
    logic                    r_vt;

    assign w_thr = (r_ang[NSTG] + pcc_pkg::ANG_RND) >>> 8;

    always_comb begin
        n_thw = w_thr;
        if (w_thr > pcc_pkg::ANG_180Q) begin
            n_thw = w_thr - pcc_pkg::ANG_360Q;
        end else if (w_thr <= -pcc_pkg::ANG_180Q) begin
            n_thw = w_thr + pcc_pkg::ANG_360Q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_th <= r_zero[NSTG] ? '0 : TH_W'(n_thw);
        if (!i_rst_n) begin
            r_vt <= 1'b0;
        end else begin
            r_vt <= r_vs[NSTG];
        end
    end

    assign o_ang.vld = r_vt;
    assign o_ang.th  = r_th;

endmodule

`default_nettype wire

FILE: hdl/pcc_shape.sv
// ----------------------------------------------------------------------------
// Phase comparator characteristic
// Maps the measured angle through the wrap, sine or triangle characteristic.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_shape (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  pcc_pkg::t_ang i_ang,
    input  pcc_pkg::t_cfg i_cfg,
    output pcc_pkg::t_shp o_shp
);

    localparam int TH_W    = pcc_pkg::TH_W;
    localparam int R_W     = pcc_pkg::R_W;
    localparam int MOD_W   = pcc_pkg::MOD_W;
    localparam int ANG_W   = pcc_pkg::ANG_W;
    localparam int SX_W    = pcc_pkg::SX_W;
    localparam int SP_W    = pcc_pkg::SP_W;
    localparam int NSTG    = pcc_pkg::NSTG;
    localparam int CHR_LAT = pcc_pkg::CHR_LAT;
    localparam int PF_PAD  = CHR_LAT - pcc_pkg::PF_LAT;
    localparam int SN_PAD  = CHR_LAT - pcc_pkg::SN_LAT;

    // Angle and valid travel alongside both characteristic pipelines.
    logic signed [TH_W-1:0] r_thd [1:CHR_LAT];
    logic                   r_vld [1:CHR_LAT];

    always_ff @(posedge i_clk) begin
        r_thd[1] <= i_ang.th;
        if (!i_rst_n) begin
            r_vld[1] <= 1'b0;
        end else begin
            r_vld[1] <= i_ang.vld;
        end
    end

    for (genvar gk = 2; gk <= CHR_LAT; gk++) begin : g_line
        always_ff @(posedge i_clk) begin
            r_thd[gk] <= r_thd[gk-1];
            if (!i_rst_n) begin
                r_vld[gk] <= 1'b0;
            end else begin
                r_vld[gk] <= r_vld[gk-1];
            end
        end
    end

    // Phase-frequency wrap: |theta + M| mod 2M by restoring subtraction.
    logic [MOD_W-1:0]        w_two;
    logic signed [R_W-1:0]   w_v;
    logic [MOD_W-1:0]        w_mag;

    assign w_two = {i_cfg.max_angle, 1'b0};
    assign w_v   = $signed({i_ang.th[TH_W-1], i_ang.th}) + $signed({2'b00, i_cfg.max_angle});
    assign w_mag = w_v[R_W-1] ? MOD_W'(-w_v) : MOD_W'(w_v);

    logic [MOD_W-1:0] r_rem [1:MOD_W+1];
    logic             r_neg [1:MOD_W+1];

    always_ff @(posedge i_clk) begin
        r_rem[1] <= w_mag;
        r_neg[1] <= w_v[R_W-1];
    end

    for (genvar gj = 0; gj < MOD_W; gj++) begin : g_mod
        logic [2*MOD_W-1:0] w_div, w_rem;
        assign w_div = {{MOD_W{1'b0}}, w_two} << (MOD_W - 1 - gj);
        assign w_rem = {{MOD_W{1'b0}}, r_rem[gj+1]};

        always_ff @(posedge i_clk) begin
            r_rem[gj+2] <= (w_rem >= w_div) ? MOD_W'(w_rem - w_div) : r_rem[gj+1];
            r_neg[gj+2] <= r_neg[gj+1];
        end
    end

    logic [MOD_W-1:0]      w_u;
    logic signed [R_W-1:0] w_t, w_th2;
    logic signed [R_W-1:0] r_pf [0:PF_PAD];

    assign w_u   = (r_neg[MOD_W+1] && (r_rem[MOD_W+1] != '0)) ?
                   (w_two - r_rem[MOD_W+1]) : r_rem[MOD_W+1];
    assign w_t   = $signed({1'b0, w_u}) - $signed({2'b00, i_cfg.max_angle});
    assign w_th2 = R_W'(r_thd[MOD_W+1]) <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_cfg.max_angle == '0) begin
            r_pf[0] <= w_th2;
        end else begin
            r_pf[0] <= w_t <<< 1;
        end
    end

    for (genvar gp = 1; gp <= PF_PAD; gp++) begin : g_pf_pad
        always_ff @(posedge i_clk) begin
            r_pf[gp] <= r_pf[gp-1];
        end
    end

    // Sinusoidal: fold into [-90, 90], then a rotation CORDIC.
    logic signed [TH_W-1:0] w_fold;

    always_comb begin
        w_fold = i_ang.th;
        if (i_ang.th > pcc_pkg::TH_90) begin
            w_fold = pcc_pkg::TH_180 - i_ang.th;
        end else if (i_ang.th < -pcc_pkg::TH_90) begin
            w_fold = -pcc_pkg::TH_180 - i_ang.th;
        end
    end

    logic signed [SX_W-1:0]  r_sx [1:NSTG+1];
    logic signed [SX_W-1:0]  r_sy [1:NSTG+1];
    logic signed [ANG_W-1:0] r_sr [1:NSTG+1];

    always_ff @(posedge i_clk) begin
        r_sx[1] <= pcc_pkg::CORDIC_X0;
        r_sy[1] <= '0;
        r_sr[1] <= ANG_W'(w_fold) <<< 8;
    end

    for (genvar gs = 0; gs < NSTG; gs++) begin : g_sin
        logic signed [SX_W-1:0] w_xs, w_ys;
        assign w_xs = r_sx[gs+1] >>> gs;
        assign w_ys = r_sy[gs+1] >>> gs;

        always_ff @(posedge i_clk) begin
            if (r_sr[gs+1] >= 0) begin
                r_sx[gs+2] <= r_sx[gs+1] - w_ys;
                r_sy[gs+2] <= r_sy[gs+1] + w_xs;
                r_sr[gs+2] <= r_sr[gs+1] - pcc_pkg::atan_val(gs);
            end else begin
                r_sx[gs+2] <= r_sx[gs+1] + w_ys;
                r_sy[gs+2] <= r_sy[gs+1] - w_xs;
                r_sr[gs+2] <= r_sr[gs+1] + pcc_pkg::atan_val(gs);
            end
        end
    end

    logic signed [SP_W-1:0] r_smul, w_sround;
    logic signed [R_W-1:0]  r_sn [0:SN_PAD];

    assign w_sround = (r_smul + pcc_pkg::SIN_RND) >>> 45;

    always_ff @(posedge i_clk) begin
        r_smul  <= SP_W'(r_sy[NSTG+1]) * SP_W'(pcc_pkg::RAD2DEG);
        r_sn[0] <= R_W'(w_sround);
    end

    for (genvar gq = 1; gq <= SN_PAD; gq++) begin : g_sn_pad
        always_ff @(posedge i_clk) begin
            r_sn[gq] <= r_sn[gq-1];
        end
    end

    // Triangle and final selection.
    logic signed [TH_W-1:0] w_thl;
    logic signed [R_W-1:0]  w_tri, n_r, r_r;
    logic                   r_vo;

    assign w_thl = r_thd[CHR_LAT];

    always_comb begin
        if (w_thl < 0) begin
            w_tri = R_W'(w_thl);
        end else if (w_thl <= pcc_pkg::TH_90) begin
            w_tri = R_W'(w_thl) <<< 1;
        end else begin
            w_tri = (R_W'(pcc_pkg::TH_180) - R_W'(w_thl)) <<< 1;
        end
    end

    always_comb begin
        case (i_cfg.mode)
            pcc_pkg::MODE_PF:  n_r = r_pf[PF_PAD];
            pcc_pkg::MODE_SIN: n_r = r_sn[SN_PAD];
            default:           n_r = w_tri;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_vld[CHR_LAT];
        end
    end

    assign o_shp.vld = r_vo;
    assign o_shp.r   = r_r;

endmodule

`default_nettype wire

FILE: hdl/phase_comparator_characteristic.sv
// ----------------------------------------------------------------------------
// Phase comparator with selectable characteristic
// Measures the phase between two complex samples and drives a scaled,
// saturated comparator output.
//
// Channel   Direction  Handshake            Payload
// input     in         start / busy         i_in1_real, i_in1_imag,
//                                           i_in2_real, i_in2_imag
// result    out        o_valid strobe       o_drive_value (Q24.24)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// A word is taken on every clock that start is high; busy is always low.
// The path runs through the angle measurement with 16 CORDIC stages, then the
// characteristic, where the 18-step modulo pipeline outlasts the sine CORDIC,
// and last the gain product and saturation registers.
// Reset clears the valid pipeline and restores the configuration defaults.
// Results appear as one-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "phase_comparator_characteristic_macros.svh"

module phase_comparator_characteristic (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output      logic                busy,
    input  wire logic signed [15:0]  i_in1_real,
    input  wire logic signed [15:0]  i_in1_imag,
    input  wire logic signed [15:0]  i_in2_real,
    input  wire logic signed [15:0]  i_in2_imag,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_wdata,
    output      logic                o_valid,
    output      logic signed [47:0]  o_drive_value
);

    localparam int P_W   = pcc_pkg::P_W;
    localparam int OUT_W = pcc_pkg::OUT_W;

    pcc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= pcc_pkg::MODE_RST;
            r_cfg.gain      <= pcc_pkg::GAIN_RST;
            r_cfg.max_angle <= pcc_pkg::MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcc_pkg::REG_MODE: r_cfg.mode      <= i_cfg_wdata[1:0];
                pcc_pkg::REG_GAIN: r_cfg.gain      <= i_cfg_wdata;
                pcc_pkg::REG_MAX:  r_cfg.max_angle <= i_cfg_wdata[pcc_pkg::MAX_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    pcc_pkg::t_ang w_ang;
    pcc_pkg::t_shp w_shp;

    pcc_angle u_angle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (start && !busy),
        .i_in1_real (i_in1_real),
        .i_in1_imag (i_in1_imag),
        .i_in2_real (i_in2_real),
        .i_in2_imag (i_in2_imag),
        .o_ang      (w_ang)
    );

    pcc_shape u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ang   (w_ang),
        .i_cfg   (r_cfg),
        .o_shp   (w_shp)
    );

    logic signed [pcc_pkg::GAIN_W-1:0] w_gain;
    logic signed [pcc_pkg::R_W-1:0]    w_r;
    logic signed [P_W-1:0]             r_prod, w_half;
    logic                              r_pvld;

    assign w_gain = r_cfg.gain;
    assign w_r    = w_shp.r;

    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(w_gain) * P_W'(w_r);
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= w_shp.vld;
        end
    end

    // Round half up from 25 to 24 fraction bits, then clamp to 48 bits.
    assign w_half = (r_prod + P_W'(1)) >>> 1;

    logic signed [OUT_W-1:0] r_drive;
    logic                    r_ovld;

    always_ff @(posedge i_clk) begin
        if (w_half > pcc_pkg::OUT_MAX) begin
            r_drive <= OUT_W'(pcc_pkg::OUT_MAX);
        end else if (w_half < pcc_pkg::OUT_MIN) begin
            r_drive <= OUT_W'(pcc_pkg::OUT_MIN);
        end else begin
            r_drive <= OUT_W'(w_half);
        end
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_pvld;
        end
    end

    assign o_valid       = r_ovld;
    assign o_drive_value = r_drive;

    `PCC_ASSERT_IMP(a_out_latency, i_clk, i_rst_n, o_valid, $past(start && !busy, pcc_pkg::TOTAL_LAT))
    `PCC_ASSERT_IMP(a_shape_latency, i_clk, i_rst_n, w_shp.vld, $past(w_ang.vld, pcc_pkg::SHAPE_LAT))
    `PCC_ASSERT_NXT(a_zero_product, i_clk, i_rst_n, r_pvld && (r_prod == '0), o_valid && (o_drive_value == '0))

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Phase comparator testbench
// Drives sample pairs through the comparator under every characteristic and
// several gain and wrap settings. A built-in predictor works out each drive
// value and a scoreboard checks the result words in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 43;
    localparam longint LIMIT = 400000;

    // Register index that the block does not decode.
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_in1_real;
    logic signed [15:0] i_in1_imag;
    logic signed [15:0] i_in2_real;
    logic signed [15:0] i_in2_imag;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [31:0]        i_cfg_wdata;
    logic               o_valid;
    logic signed [47:0] o_drive_value;

    phase_comparator_characteristic i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in1_real(i_in1_real), .i_in1_imag(i_in1_imag),
        .i_in2_real(i_in2_real), .i_in2_imag(i_in2_imag),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_drive_value(o_drive_value)
    );

    int errors;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Shadow configuration and predictor.
    logic [1:0]         cfg_mode;
    logic signed [31:0] cfg_gain;
    logic [16:0]        cfg_max;

    function automatic longint atan_step(input int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint phase_q88(input longint x0, input longint y0);
        longint x, y, ang, t, xs, ys, th;
        x = x0; y = y0; ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin x = y; y = -t; ang = 23040 * 256; end
            else begin x = -y; y = t; ang = -23040 * 256; end
        end
        for (int i = 0; i < pcc_pkg::CORDIC_STAGES; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (y >= 0) begin x = x + ys; y = y - xs; ang += atan_step(i); end
            else begin x = x - ys; y = y + xs; ang -= atan_step(i); end
        end
        th = (ang + 128) >>> 8;
        if (th > 46080) th -= 92160;
        else if (th <= -46080) th += 92160;
        return th;
    endfunction

    function automatic longint sine_scaled(input longint th0);
        longint x, y, res, th, xs, ys;
        th = th0;
        x = 652032874; y = 0;
        if (th > 23040) th = 46080 - th;
        else if (th < -23040) th = -46080 - th;
        res = th * 256;
        for (int i = 0; i < pcc_pkg::CORDIC_STAGES; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (res >= 0) begin x = x - ys; y = y + xs; res -= atan_step(i); end
            else begin x = x + ys; y = y - xs; res += atan_step(i); end
        end
        return (y * 961263669 + (longint'(1) <<< 44)) >>> 45;
    endfunction

    function automatic logic signed [47:0] predict_drive(
        input longint a, input longint b, input longint c, input longint d);
        longint th, t, r, two, o;
        th = phase_q88(a * c + b * d, b * c - a * d);
        if (cfg_mode == pcc_pkg::MODE_PF) begin
            t = th;
            if (cfg_max > 0) begin
                two = 2 * longint'(cfg_max);
                t = (th + longint'(cfg_max)) % two;
                if (t < 0) t += two;
                t -= longint'(cfg_max);
            end
            r = 2 * t;
        end else if (cfg_mode == pcc_pkg::MODE_SIN) begin
            r = sine_scaled(th);
        end else begin
            if (th < 0) r = th;
            else if (th <= 23040) r = 2 * th;
            else r = 2 * (46080 - th);
        end
        o = (longint'(cfg_gain) * r + 1) >>> 1;
        if (o > 64'sh7FFF_FFFF_FFFF) o = 64'sh7FFF_FFFF_FFFF;
        if (o < -64'sh8000_0000_0000) o = -64'sh8000_0000_0000;
        return o[47:0];
    endfunction

    class drive_scoreboard;
        logic signed [47:0] pending[$];
        int checked;

        function void note_word(input logic signed [47:0] v);
            pending.push_back(v);
        endfunction

        task check_word(input logic signed [47:0] got);
            logic signed [47:0] want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result word %0d", got));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("drive_value got %0d want %0d", got, want));
        endtask
    endclass

    drive_scoreboard board = new();

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    longint cycles;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout with %0d words pending", board.pending.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_word(o_drive_value);
    end

    // Holds the write for one edge, then idles before it returns.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pcc_pkg::REG_MODE: cfg_mode = v[1:0];
            pcc_pkg::REG_GAIN: cfg_gain = v;
            pcc_pkg::REG_MAX:  cfg_max  = v[16:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Sends one word; start stays high when the next word follows at once.
    task automatic send_word(input logic signed [15:0] a, b, c, d,
                             input bit keep);
        start      <= 1'b1;
        i_in1_real <= a; i_in1_imag <= b;
        i_in2_real <= c; i_in2_imag <= d;
        do @(posedge i_clk); while (busy);
        board.note_word(predict_drive(a, b, c, d));
        if (!keep) start <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 6)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_burst(input int n);
        int gap, len, sent;
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 30);
            for (int k = 0; k < len && sent < n; k++) begin
                send_word(rand_sample(), rand_sample(), rand_sample(),
                          rand_sample(), (k < len - 1) && (sent < n - 1));
                sent++;
            end
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    logic signed [15:0] ext[6] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1,
                                   -16'sd1, 16'sh4000};
    logic [31:0] gains[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd65536,
                              32'hFFFF_0000, 32'h0012_3456};
    logic [16:0] maxes[5] = '{17'd0, 17'd92160, 17'h1FFFF, 17'd1, 17'd23040};

    initial begin
        errors = 0; cycles = 0;
        cfg_mode = pcc_pkg::MODE_RST; cfg_gain = pcc_pkg::GAIN_RST;
        cfg_max = pcc_pkg::MAX_RST;
        i_rst_n = 0; start = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_wdata = '0;
        i_in1_real = 0; i_in1_imag = 0; i_in2_real = 0; i_in2_imag = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero product, axis and quadrant cases, extremes.
        send_word(0, 0, 0, 0, 1);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1);
        send_word(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1);
        send_word(-16'sd1000, 0, 16'sd1000, 0, 1);
        send_word(0, 16'sd1000, 16'sd1000, 0, 1);
        send_word(0, -16'sd1000, 16'sd1000, 0, 1);
        send_word(-16'sd5, 16'sd5, 16'sd5, 0, 1);
        send_word(-16'sd5, -16'sd5, 16'sd5, 0, 1);
        for (int i = 0; i < 6; i++)
            send_word(ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 4) % 6],
                      i < 5);
        drain();

        // Sweep of settings; mode 3 and an unused register index included.
        for (int m = 0; m < 4; m++) begin
            for (int g = 0; g < 6; g++) begin
                write_reg(pcc_pkg::REG_MODE, 32'(m) | 32'hFFFF_FFFC);
                write_reg(pcc_pkg::REG_GAIN, gains[g]);
                write_reg(pcc_pkg::REG_MAX, {15'h7FFF, maxes[(m + g) % 5]});
                write_reg(REG_SPARE, $urandom);
                random_burst(55);
                drain();
            end
        end
        random_burst(100);
        drain();

        $display("Checked %0d result words across all four mode codes,", board.checked);
        $display("six gains from both extremes and five wrap limits.");
        if (errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
